[hdl/primitive_assembly_to_list_core_defines.svh]
// assertion macros for the primitive assembly core
// no dependencies; SYNTH removes the bodies
`ifndef PRIMITIVE_ASSEMBLY_TO_LIST_CORE_DEFINES_SVH
`define PRIMITIVE_ASSEMBLY_TO_LIST_CORE_DEFINES_SVH
`ifndef SYNTH
`define PATL_ASSERT_IMPLY(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("patl implication check failed");
`define PATL_ASSERT_NEVER(lbl, ck, rs, cond) \
  lbl: assert property (@(posedge ck) disable iff (rs) !(cond)) \
    else $error("patl forbidden condition seen");
`else
`define PATL_ASSERT_IMPLY(lbl, ck, rs, ante, cons)
`define PATL_ASSERT_NEVER(lbl, ck, rs, cond)
`endif
`endif

[hdl/patl_pkg.sv]
// types, codes and helpers for the primitive assembly core
// no dependencies
package patl_pkg;

  localparam int CFG_INDEX_BITS = 32;
  localparam int CFG_DATA_BITS  = 32;
  localparam int QUEUE_DEPTH    = 4;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_TOPOLOGY     = 32'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_INDEX_FORMAT = 32'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_VERT_LIMIT   = 32'd2;

  localparam logic [2:0] TOPO_POINT_LIST = 3'd0;
  localparam logic [2:0] TOPO_LINE_LIST  = 3'd1;
  localparam logic [2:0] TOPO_LINE_STRIP = 3'd2;
  localparam logic [2:0] TOPO_TRI_LIST   = 3'd3;
  localparam logic [2:0] TOPO_TRI_STRIP  = 3'd4;
  localparam logic [2:0] TOPO_TRI_FAN    = 3'd5;

  localparam logic [1:0] FMT_DIRECT = 2'd0;
  localparam logic [1:0] FMT_16     = 2'd1;
  localparam logic [1:0] FMT_32     = 2'd2;

  localparam logic [1:0] KIND_POINTS = 2'd0;
  localparam logic [1:0] KIND_LINES  = 2'd1;
  localparam logic [1:0] KIND_TRIS   = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_RANGE    = 2'd1;
  localparam logic [1:0] ST_NO_PRIM  = 2'd2;
  localparam logic [1:0] ST_OVERFLOW = 2'd3;

  typedef struct packed {
    logic [2:0]  topology;
    logic [1:0]  index_format;
    logic [31:0] vert_limit;
  } cfg_t;

  // one queued record: a whole primitive or a status-only item
  typedef struct packed {
    logic            status_only;
    logic [1:0]      status;
    logic [1:0]      last_corner;
    logic [2:0][31:0] src;
    logic [31:0]     pid;
    logic [1:0]      kind;
    logic            last;
  } rec_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic logic [1:0] kind_of(input logic [2:0] topo);
    logic [1:0] k;
    case (topo)
      TOPO_LINE_LIST, TOPO_LINE_STRIP: k = KIND_LINES;
      TOPO_TRI_LIST, TOPO_TRI_STRIP, TOPO_TRI_FAN: k = KIND_TRIS;
      default: k = KIND_POINTS;
    endcase
    return k;
  endfunction

endpackage

[hdl/patl_if.sv]
// valid/ready channels of the primitive assembly core
// no dependencies
interface patl_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] index_word;
  logic        last_index;
  modport source (output valid, index_word, last_index, input ready);
  modport sink (input valid, index_word, last_index, output ready);
endinterface

interface patl_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] vtx_index;
  logic [31:0] primitive_id;
  logic [1:0]  corner;
  logic [1:0]  list_kind;
  logic [1:0]  status;
  logic        last;
  modport source (output valid, vtx_index, primitive_id, corner, list_kind, status, last,
                  input ready);
  modport sink (input valid, vtx_index, primitive_id, corner, list_kind, status, last,
                output ready);
endinterface

[hdl/primitive_assembly_to_list_core.sv]
// top level of the primitive assembly core: config registers, front, queue, back
// depends on patl_pkg, patl_if, patl_front, patl_queue, patl_back and the defines header
//
// channel  dir  payload                                                    handshake
// in_ch    in   index_word[31:0], last_index                               valid/ready
// out_ch   out  vtx_index, primitive_id, corner, list_kind, status, last   valid/ready
// cfg      in   cfg_index[31:0], cfg_data[31:0]                            cfg_we
//
// an index item is taken whenever the queue is not full; each triangle gives three result items,
// each line two, each point one, at one result item per cycle from the back unless the output stalls
// so strip and fan triangles, three result items per index item, are paced by the output port
// a four-record queue lets the front keep taking items while results wait
// rst is synchronous, clears the draw state, queue and output register, and resets the config registers

`include "primitive_assembly_to_list_core_defines.svh"

module primitive_assembly_to_list_core import patl_pkg::*; #(
  parameter int INDEX_BITS = 32
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,
  patl_in_if.sink                   in_ch,
  patl_out_if.source                out_ch
);

  cfg_t    cfg;
  q_stat_t q_stat;
  logic    push;
  rec_t    push_rec;
  logic    pop;
  rec_t    head;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.topology <= TOPO_POINT_LIST;
      cfg.index_format <= FMT_DIRECT;
      cfg.vert_limit <= 32'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TOPOLOGY: cfg.topology <= cfg_data[2:0];
        CFG_INDEX_FORMAT: cfg.index_format <= cfg_data[1:0];
        CFG_VERT_LIMIT: cfg.vert_limit <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  patl_front #(.INDEX_BITS(INDEX_BITS)) u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_ch    (in_ch),
    .q_stat   (q_stat),
    .push     (push),
    .push_rec (push_rec)
  );

  patl_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_rec (push_rec),
    .pop      (pop),
    .head     (head),
    .q_stat   (q_stat)
  );

  patl_back u_back (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .head   (head),
    .q_stat (q_stat),
    .pop    (pop),
    .out_ch (out_ch)
  );

  `PATL_ASSERT_NEVER(a_no_push_when_full, clk, rst, push && q_stat.full)
  `PATL_ASSERT_NEVER(a_no_pop_when_empty, clk, rst, pop && q_stat.empty)
  `PATL_ASSERT_IMPLY(a_no_prim_is_last, clk, rst, out_ch.valid && (out_ch.status == ST_NO_PRIM), out_ch.last && (out_ch.primitive_id == 32'd0))
  `PATL_ASSERT_IMPLY(a_corner_has_pid, clk, rst, out_ch.valid && (out_ch.corner != 2'd0), out_ch.primitive_id != 32'd0)

endmodule

[hdl/patl_front.sv]
// front: accepts index items, tracks strip/fan state, builds primitive records
// depends on patl_pkg and patl_if
module patl_front import patl_pkg::*; #(
  parameter int INDEX_BITS = 32
) (
  input  logic      clk,
  input  logic      rst,
  input  cfg_t      cfg,
  patl_in_if.sink   in_ch,
  input  q_stat_t   q_stat,
  output logic      push,
  output rec_t      push_rec
);

  localparam logic [31:0] IDX_MASK = 32'((64'd1 << INDEX_BITS) - 64'd1);

  logic [31:0] older_index, older_index_next;
  logic [31:0] newer_index, newer_index_next;
  logic [31:0] fan_first_index, fan_first_index_next;
  logic [32:0] indices_seen, indices_seen_next;
  logic [31:0] primitive_counter, primitive_counter_next;
  logic [1:0]  corner_phase, corner_phase_next;

  logic        accept;
  logic [1:0]  phase;
  logic [31:0] cur;
  logic [1:0]  n;
  logic [2:0][31:0] corners;
  logic        ovf;
  logic [1:0]  kind;

  assign in_ch.ready = !q_stat.full;
  assign accept = in_ch.valid && in_ch.ready;
  assign kind = kind_of(cfg.topology);
  assign phase = corner_phase[1] ? 2'd2 : corner_phase;

  always_comb begin
    case (cfg.index_format)
      FMT_DIRECT: cur = indices_seen[31:0];
      FMT_16: cur = {16'd0, in_ch.index_word[15:0]};
      default: cur = in_ch.index_word & IDX_MASK;
    endcase
  end

  always_comb begin
    n = 2'd0;
    corners = '0;
    case (cfg.topology)
      TOPO_POINT_LIST: begin
        corners[0] = cur;
        n = 2'd1;
      end
      TOPO_LINE_LIST, TOPO_LINE_STRIP: begin
        if (phase != 2'd0) begin
          corners[0] = newer_index;
          corners[1] = cur;
          n = 2'd2;
        end
      end
      TOPO_TRI_LIST, TOPO_TRI_STRIP: begin
        if (phase == 2'd2) begin
          corners[0] = older_index;
          corners[1] = newer_index;
          corners[2] = cur;
          n = 2'd3;
        end
      end
      TOPO_TRI_FAN: begin
        if (phase == 2'd2) begin
          corners[0] = fan_first_index;
          corners[1] = newer_index;
          corners[2] = cur;
          n = 2'd3;
        end
      end
      default: n = 2'd0;
    endcase
  end

  assign ovf = indices_seen[32] || ((n != 2'd0) && (primitive_counter == '1));

  // record out
  always_comb begin
    push_rec = '0;
    push_rec.kind = kind;
    push_rec.last = in_ch.last_index;
    push = 1'b0;
    if (ovf) begin
      push_rec.status_only = 1'b1;
      push_rec.status = ST_OVERFLOW;
      push = accept;
    end else if (n != 2'd0) begin
      push_rec.last_corner = n - 2'd1;
      push_rec.src = corners;
      push_rec.pid = primitive_counter + 32'd1;
      push = accept;
    end else if (in_ch.last_index) begin
      push_rec.status_only = 1'b1;
      push_rec.status = (primitive_counter == '0) ? ST_NO_PRIM : ST_OK;
      push = accept;
    end
  end

  // draw state advance
  always_comb begin
    older_index_next = older_index;
    newer_index_next = newer_index;
    fan_first_index_next = fan_first_index;
    indices_seen_next = indices_seen;
    primitive_counter_next = primitive_counter;
    corner_phase_next = corner_phase;
    if (accept) begin
      if (in_ch.last_index) begin
        older_index_next = '0;
        newer_index_next = '0;
        fan_first_index_next = '0;
        indices_seen_next = '0;
        primitive_counter_next = '0;
        corner_phase_next = '0;
      end else if (!ovf) begin
        case (cfg.topology)
          TOPO_POINT_LIST: corner_phase_next = 2'd0;
          TOPO_LINE_LIST, TOPO_TRI_LIST:
            corner_phase_next = (n != 2'd0) ? 2'd0 : phase + 2'd1;
          TOPO_LINE_STRIP: corner_phase_next = 2'd1;
          TOPO_TRI_FAN: begin
            if (phase == 2'd0) fan_first_index_next = cur;
            corner_phase_next = (phase < 2'd2) ? phase + 2'd1 : 2'd2;
          end
          TOPO_TRI_STRIP: corner_phase_next = (phase < 2'd2) ? phase + 2'd1 : 2'd2;
          default: corner_phase_next = 2'd0;
        endcase
        older_index_next = newer_index;
        newer_index_next = cur;
        indices_seen_next = indices_seen + 33'd1;
        if (n != 2'd0) primitive_counter_next = primitive_counter + 32'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      older_index <= '0;
      newer_index <= '0;
      fan_first_index <= '0;
      indices_seen <= '0;
      primitive_counter <= '0;
      corner_phase <= '0;
    end else begin
      older_index <= older_index_next;
      newer_index <= newer_index_next;
      fan_first_index <= fan_first_index_next;
      indices_seen <= indices_seen_next;
      primitive_counter <= primitive_counter_next;
      corner_phase <= corner_phase_next;
    end
  end

endmodule

[hdl/patl_queue.sv]
// short record queue between front and back
// depends on patl_pkg
module patl_queue import patl_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  rec_t    push_rec,
  input  logic    pop,
  output rec_t    head,
  output q_stat_t q_stat
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

  rec_t             slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr, wr_ptr_next;
  logic [PTR_W-1:0] rd_ptr, rd_ptr_next;
  logic [CNT_W-1:0] count, count_next;

  assign head = slots[rd_ptr];
  assign q_stat.full = (count == CNT_W'(DEPTH));
  assign q_stat.empty = (count == '0);

  always_comb begin
    wr_ptr_next = wr_ptr;
    rd_ptr_next = rd_ptr;
    count_next = count;
    if (push) wr_ptr_next = (wr_ptr == PTR_LAST) ? '0 : wr_ptr + PTR_W'(1);
    if (pop) rd_ptr_next = (rd_ptr == PTR_LAST) ? '0 : rd_ptr + PTR_W'(1);
    if (push && !pop) count_next = count + CNT_W'(1);
    else if (pop && !push) count_next = count - CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_rec;
  end

endmodule

[hdl/patl_back.sv]
// back: unrolls each record into result items, one per cycle unless stalled, registered output
// depends on patl_pkg and patl_if
module patl_back import patl_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  cfg_t     cfg,
  input  rec_t     head,
  input  q_stat_t  q_stat,
  output logic     pop,
  patl_out_if.source out_ch
);

  rec_t        hold;
  logic        hold_valid, hold_valid_next;
  logic [1:0]  corner_idx, corner_idx_next;
  logic        load;
  logic        release_rec;
  logic [31:0] src_sel;

  logic        out_valid, out_valid_next;
  logic [31:0] vtx_index, primitive_id;
  logic [1:0]  corner, list_kind, status;
  logic        last;

  assign load = hold_valid && (!out_valid || out_ch.ready);
  assign release_rec = load && (corner_idx == hold.last_corner);
  assign pop = !q_stat.empty && (!hold_valid || release_rec);
  assign src_sel = hold.src[corner_idx];

  always_comb begin
    hold_valid_next = hold_valid;
    corner_idx_next = corner_idx;
    if (pop) begin
      hold_valid_next = 1'b1;
      corner_idx_next = '0;
    end else if (release_rec) begin
      hold_valid_next = 1'b0;
    end else if (load) begin
      corner_idx_next = corner_idx + 2'd1;
    end
    out_valid_next = out_valid;
    if (load) out_valid_next = 1'b1;
    else if (out_ch.ready) out_valid_next = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
      corner_idx <= '0;
      out_valid <= 1'b0;
    end else begin
      hold_valid <= hold_valid_next;
      corner_idx <= corner_idx_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) hold <= head;
    if (load) begin
      vtx_index <= hold.status_only ? 32'd0 : src_sel;
      primitive_id <= hold.status_only ? 32'd0 : hold.pid;
      corner <= hold.status_only ? 2'd0 : corner_idx;
      list_kind <= hold.kind;
      if (hold.status_only) status <= hold.status;
      else status <= (src_sel >= cfg.vert_limit) ? ST_RANGE : ST_OK;
      last <= hold.last && (corner_idx == hold.last_corner);
    end
  end

  assign out_ch.valid = out_valid;
  assign out_ch.vtx_index = vtx_index;
  assign out_ch.primitive_id = primitive_id;
  assign out_ch.corner = corner;
  assign out_ch.list_kind = list_kind;
  assign out_ch.status = status;
  assign out_ch.last = last;

endmodule

[test/testbench.sv]
// self-checking testbench for primitive_assembly_to_list_core
// drives index items and register writes, predicts every corner item and checks it
// depends on patl_pkg, patl_if and the core
`timescale 1ns / 1ps

module testbench;
  import patl_pkg::*;

  localparam int INDEX_BITS = 32;
  localparam logic [31:0] INDEX_MASK = (INDEX_BITS == 32) ? 32'hFFFF_FFFF :
                                       ((32'd1 << INDEX_BITS) - 32'd1);
  localparam int RANDOM_ITEMS = 320;
  localparam int DRAIN_CYCLES = 20;
  localparam int TIMEOUT_NS   = 5_000_000;
  localparam int MAX_REPORTS  = 10;

  typedef struct packed {
    logic [31:0] vtx_index;
    logic [31:0] primitive_id;
    logic [1:0]  corner;
    logic [1:0]  list_kind;
    logic [1:0]  status;
    logic        last;
  } corner_item_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [CFG_DATA_BITS-1:0]  cfg_data;

  patl_in_if  in_if ();
  patl_out_if out_if ();

  primitive_assembly_to_list_core #(.INDEX_BITS(INDEX_BITS)) u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_if),
    .out_ch    (out_if)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // register copies and draw state of the predictor
  logic [2:0]  topo_reg;
  logic [1:0]  fmt_reg;
  logic [31:0] vcount_reg;
  logic [31:0] older_idx;
  logic [31:0] newer_idx;
  logic [31:0] fan_first;
  logic [32:0] words_taken;
  logic [31:0] prims_done;
  logic [1:0]  phase;

  corner_item_t corner_queue[$];

  int errors;
  int reported;
  int items_sent;
  int results_checked;
  int reg_writes;
  int rx_hold;
  int rx_stall;
  bit no_idle;

  function automatic int idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic corner_item_t status_item(input logic [1:0] kind, input logic [1:0] st,
                                               input logic fin);
    corner_item_t s;
    s.vtx_index    = '0;
    s.primitive_id = '0;
    s.corner       = 2'd0;
    s.list_kind    = kind;
    s.status       = st;
    s.last         = fin;
    return s;
  endfunction

  task automatic clear_draw_state();
    older_idx   = '0;
    newer_idx   = '0;
    fan_first   = '0;
    words_taken = '0;
    prims_done  = '0;
    phase       = 2'd0;
  endtask

  task automatic assemble_index(input logic [31:0] word, input logic fin);
    logic [1:0]   kind;
    logic [1:0]   ph;
    logic [31:0]  cur;
    logic [31:0]  pid;
    logic [31:0]  c [0:2];
    int           n;
    int           j;
    corner_item_t item;
    case (topo_reg)
      TOPO_LINE_LIST, TOPO_LINE_STRIP: kind = KIND_LINES;
      TOPO_TRI_LIST, TOPO_TRI_STRIP, TOPO_TRI_FAN: kind = KIND_TRIS;
      default: kind = KIND_POINTS;
    endcase
    ph = (phase > 2'd2) ? 2'd2 : phase;
    n = 0;
    c[0] = '0;
    c[1] = '0;
    c[2] = '0;
    if (words_taken[32]) begin
      corner_queue.push_back(status_item(kind, ST_OVERFLOW, fin));
      if (fin) clear_draw_state();
      return;
    end
    case (fmt_reg)
      FMT_DIRECT: cur = words_taken[31:0];
      FMT_16: cur = {16'h0000, word[15:0]};
      default: cur = word & INDEX_MASK;
    endcase
    case (topo_reg)
      TOPO_POINT_LIST: begin
        c[0] = cur;
        n = 1;
      end
      TOPO_LINE_LIST, TOPO_LINE_STRIP: begin
        if (ph != 2'd0) begin
          c[0] = newer_idx;
          c[1] = cur;
          n = 2;
        end
      end
      TOPO_TRI_LIST, TOPO_TRI_STRIP: begin
        if (ph == 2'd2) begin
          c[0] = older_idx;
          c[1] = newer_idx;
          c[2] = cur;
          n = 3;
        end
      end
      TOPO_TRI_FAN: begin
        if (ph == 2'd2) begin
          c[0] = fan_first;
          c[1] = newer_idx;
          c[2] = cur;
          n = 3;
        end
      end
      default: n = 0;
    endcase
    if (n > 0 && prims_done == 32'hFFFF_FFFF) begin
      corner_queue.push_back(status_item(kind, ST_OVERFLOW, fin));
      if (fin) clear_draw_state();
      return;
    end
    case (topo_reg)
      TOPO_LINE_LIST, TOPO_TRI_LIST: phase = (n > 0) ? 2'd0 : ph + 2'd1;
      TOPO_LINE_STRIP: phase = 2'd1;
      TOPO_TRI_FAN: begin
        if (ph == 2'd0) fan_first = cur;
        phase = (ph < 2'd2) ? ph + 2'd1 : 2'd2;
      end
      TOPO_TRI_STRIP: phase = (ph < 2'd2) ? ph + 2'd1 : 2'd2;
      default: phase = 2'd0;
    endcase
    older_idx = newer_idx;
    newer_idx = cur;
    words_taken = words_taken + 33'd1;
    if (n > 0) begin
      pid = prims_done + 32'd1;
      for (j = 0; j < n; j++) begin
        item.vtx_index    = c[j];
        item.primitive_id = pid;
        item.corner       = 2'(j);
        item.list_kind    = kind;
        item.status       = (c[j] >= vcount_reg) ? ST_RANGE : ST_OK;
        item.last         = fin && (j == n - 1);
        corner_queue.push_back(item);
      end
      prims_done = pid;
    end else if (fin) begin
      corner_queue.push_back(status_item(kind, (prims_done == '0) ? ST_NO_PRIM : ST_OK, 1'b1));
    end
    if (fin) clear_draw_state();
  endtask

  // sender: offers one item, returns at the edge that accepts it
  task automatic send_index(input logic [31:0] word, input logic fin);
    int gap;
    gap = idle_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_if.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_if.valid      = 1'b1;
    in_if.index_word = word;
    in_if.last_index = fin;
    do @(posedge clk); while (!in_if.ready);
    assemble_index(word, fin);
    items_sent++;
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_if.valid = 1'b0;
    while (corner_queue.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [31:0] idx, input logic [31:0] val);
    wait_idle();
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    case (idx)
      CFG_TOPOLOGY: topo_reg = val[2:0];
      CFG_INDEX_FORMAT: fmt_reg = val[1:0];
      CFG_VERT_LIMIT: vcount_reg = val;
      default: ;
    endcase
    reg_writes++;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // result side: random stalls plus a long hold-off on request
  always @(negedge clk) begin
    if (rx_hold > 0) begin
      out_if.ready = 1'b0;
      rx_hold--;
    end else if (rx_stall > 0) begin
      out_if.ready = 1'b0;
      rx_stall--;
    end else begin
      out_if.ready = 1'b1;
      if (!no_idle && $urandom_range(0, 3) == 0) rx_stall = idle_gap();
    end
  end

  always @(posedge clk) begin
    corner_item_t want;
    if (!rst && out_if.valid && out_if.ready) begin
      results_checked++;
      if (corner_queue.size() == 0) begin
        errors++;
        if (reported < MAX_REPORTS)
          $display("unexpected item: src %0h pid %0h corner %0d kind %0d status %0d last %0b",
                   out_if.vtx_index, out_if.primitive_id, out_if.corner,
                   out_if.list_kind, out_if.status, out_if.last);
        reported++;
      end else begin
        want = corner_queue.pop_front();
        if (want.vtx_index !== out_if.vtx_index || want.primitive_id !== out_if.primitive_id
            || want.corner !== out_if.corner || want.list_kind !== out_if.list_kind
            || want.status !== out_if.status || want.last !== out_if.last) begin
          errors++;
          if (reported < MAX_REPORTS)
            $display("mismatch: expected src %0h pid %0h corner %0d kind %0d status %0d last %0b",
                     want.vtx_index, want.primitive_id, want.corner, want.list_kind,
                     want.status, want.last, "\n          actual   src %0h pid %0h corner %0d",
                     out_if.vtx_index, out_if.primitive_id, out_if.corner,
                     " kind %0d status %0d last %0b",
                     out_if.list_kind, out_if.status, out_if.last);
          reported++;
        end
      end
    end
  end

  task automatic test_topologies();
    write_reg(CFG_INDEX_FORMAT, 32'(FMT_32));
    write_reg(CFG_VERT_LIMIT, 32'hFFFF_FFFF);
    write_reg(CFG_TOPOLOGY, 32'(TOPO_POINT_LIST));
    send_index(32'h0000_0000, 1'b0);
    send_index(32'hFFFF_FFFF, 1'b1);
    // partial line at the end is dropped
    write_reg(CFG_TOPOLOGY, 32'(TOPO_LINE_LIST));
    send_index(32'h0000_0005, 1'b0);
    send_index(32'h1234_5678, 1'b0);
    send_index(32'h0000_0009, 1'b1);
    write_reg(CFG_TOPOLOGY, 32'(TOPO_LINE_STRIP));
    send_index(32'd1, 1'b0);
    send_index(32'd2, 1'b0);
    send_index(32'd3, 1'b1);
    write_reg(CFG_TOPOLOGY, 32'(TOPO_TRI_LIST));
    send_index(32'd7, 1'b0);
    send_index(32'd8, 1'b0);
    send_index(32'hFFFF_FFFE, 1'b1);
    write_reg(CFG_TOPOLOGY, 32'(TOPO_TRI_STRIP));
    send_index(32'd10, 1'b0);
    send_index(32'd11, 1'b0);
    send_index(32'd12, 1'b0);
    send_index(32'd13, 1'b1);
    write_reg(CFG_TOPOLOGY, 32'(TOPO_TRI_FAN));
    send_index(32'd20, 1'b0);
    send_index(32'd21, 1'b0);
    send_index(32'd22, 1'b0);
    send_index(32'd23, 1'b1);
  endtask

  task automatic test_index_formats();
    // direct order with a zero vertex count flags every corner
    write_reg(CFG_INDEX_FORMAT, 32'(FMT_DIRECT));
    write_reg(CFG_VERT_LIMIT, 32'd0);
    write_reg(CFG_TOPOLOGY, 32'(TOPO_TRI_LIST));
    send_index(32'hDEAD_BEEF, 1'b0);
    send_index(32'h0000_0000, 1'b0);
    send_index(32'hFFFF_FFFF, 1'b1);
    write_reg(CFG_INDEX_FORMAT, 32'(FMT_16));
    write_reg(CFG_VERT_LIMIT, 32'h0000_1235);
    write_reg(CFG_TOPOLOGY, 32'(TOPO_POINT_LIST));
    send_index(32'hABCD_1234, 1'b0);
    send_index(32'hFFFF_FFFF, 1'b1);
  endtask

  task automatic test_draw_end_cases();
    // unknown topology and format 3: words counted, no primitive ever
    write_reg(CFG_INDEX_FORMAT, 32'd3);
    write_reg(CFG_TOPOLOGY, 32'd6);
    send_index(32'd4, 1'b0);
    send_index(32'd5, 1'b1);
    write_reg(CFG_TOPOLOGY, 32'd7);
    send_index(32'd6, 1'b1);
    write_reg(CFG_TOPOLOGY, 32'(TOPO_TRI_LIST));
    send_index(32'd1, 1'b1);
  endtask

  task automatic test_topology_change();
    write_reg(CFG_VERT_LIMIT, 32'd100);
    write_reg(CFG_TOPOLOGY, 32'(TOPO_TRI_STRIP));
    send_index(32'd30, 1'b0);
    send_index(32'd31, 1'b0);
    write_reg(CFG_TOPOLOGY, 32'(TOPO_LINE_LIST));
    send_index(32'd132, 1'b1);
  endtask

  task automatic test_random_draws();
    int taken;
    int phase_no;
    int draws;
    int len;
    int k;
    int r;
    int i;
    logic [2:0]  topo;
    logic [31:0] vc;
    logic [31:0] w;
    logic        open_draw;
    taken = 0;
    phase_no = 0;
    while (taken < RANDOM_ITEMS) begin
      r = $urandom_range(0, 15);
      topo = (r < 14) ? 3'(r % 6) : 3'(r - 8);
      case ($urandom_range(0, 5))
        0: vc = 32'd0;
        1: vc = 32'hFFFF_FFFF;
        2: vc = $urandom_range(1, 16);
        3: vc = $urandom;
        default: vc = $urandom_range(17, 400);
      endcase
      write_reg(CFG_TOPOLOGY, 32'(topo));
      write_reg(CFG_INDEX_FORMAT, $urandom_range(0, 3));
      write_reg(CFG_VERT_LIMIT, vc);
      no_idle = (phase_no % 6 == 3);
      draws = $urandom_range(1, 4);
      repeat (draws) begin
        k = $urandom_range(1, 5);
        if ($urandom_range(0, 9) < 8) begin
          case (topo)
            TOPO_POINT_LIST: len = k;
            TOPO_LINE_LIST: len = 2 * k;
            TOPO_LINE_STRIP: len = k + 1;
            TOPO_TRI_LIST: len = 3 * k;
            TOPO_TRI_STRIP, TOPO_TRI_FAN: len = k + 2;
            default: len = k;
          endcase
        end else begin
          len = $urandom_range(1, 9);
        end
        // now and then a draw is left open across the next register change
        open_draw = ($urandom_range(0, 9) == 0);
        for (i = 0; i < len; i++) begin
          if (vc != 32'd0 && $urandom_range(0, 9) < 7) w = $urandom % vc;
          else w = $urandom;
          if (fmt_reg == FMT_16 && $urandom_range(0, 1) == 1) w[31:16] = 16'($urandom);
          send_index(w, (i == len - 1) && !open_draw);
        end
        taken += len;
      end
      phase_no++;
    end
    no_idle = 1'b0;
  endtask

  task automatic test_output_stall();
    int i;
    write_reg(CFG_TOPOLOGY, 32'(TOPO_TRI_LIST));
    write_reg(CFG_INDEX_FORMAT, 32'(FMT_32));
    write_reg(CFG_VERT_LIMIT, 32'd1000);
    no_idle = 1'b1;
    @(posedge clk);
    rx_hold = 150;
    for (i = 0; i < 30; i++) send_index($urandom_range(0, 1100), i == 29);
    no_idle = 1'b0;
    wait_idle();
  endtask

  task automatic test_sender_pause();
    int i;
    write_reg(CFG_TOPOLOGY, 32'(TOPO_TRI_FAN));
    for (i = 0; i < 6; i++) send_index($urandom_range(0, 1100), 1'b0);
    wait_idle();
    for (i = 0; i < 6; i++) send_index($urandom_range(0, 1100), i == 5);
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_if.valid = 1'b0;
    in_if.index_word = '0;
    in_if.last_index = 1'b0;
    out_if.ready = 1'b0;
    topo_reg = TOPO_POINT_LIST;
    fmt_reg = FMT_DIRECT;
    vcount_reg = 32'd1;
    clear_draw_state();
    errors = 0;
    reported = 0;
    items_sent = 0;
    results_checked = 0;
    reg_writes = 0;
    rx_hold = 0;
    rx_stall = 0;
    no_idle = 1'b0;
    repeat (5) @(negedge clk);
    rst = 1'b0;

    test_topologies();
    test_index_formats();
    test_draw_end_cases();
    test_topology_change();
    test_output_stall();
    test_sender_pause();
    test_random_draws();

    wait_idle();
    if (corner_queue.size() != 0) errors++;
    $display("run covered %0d index items and %0d register writes, %0d result items checked",
             items_sent, reg_writes, results_checked);
    $display("all six topologies, unknown codes, every index format, output hold-off; %0d errors",
             errors);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("CHECK FAILED");
    $finish;
  end

endmodule
